@@ design/fau_pkg.sv @@
package fau_pkg;

  // shared multiplier operand width: holds any signed 32-bit value or 2^31
  localparam int MUL_W  = 33;
  localparam int DIV_W  = 48;
  localparam int DVS_W  = 32;
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;

  localparam logic signed [31:0] ESCAPE_FACTOR_Q16        = 32'sd65536;
  localparam logic signed [31:0] PREDATOR_ACCEL_BOOST_Q16 = 32'sd98304;

  localparam logic [2:0] CFG_ALIGN_W   = 3'd0;
  localparam logic [2:0] CFG_COH_W     = 3'd1;
  localparam logic [2:0] CFG_SEP_W     = 3'd2;
  localparam logic [2:0] CFG_SEP_DIST  = 3'd3;
  localparam logic [2:0] CFG_ACC_SCALE = 3'd4;
  localparam logic [2:0] CFG_MAX_FORCE = 3'd5;
  localparam logic [2:0] CFG_WORLD_W   = 3'd6;
  localparam logic [2:0] CFG_WORLD_H   = 3'd7;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
    logic signed [39:0] r;
    if (v > 42'sd549755813887) r = 40'sh7fffffffff;
    else if (v < -42'sd549755813888) r = 40'sh8000000000;
    else r = v[39:0];
    return r;
  endfunction

  // q16.16 product: truncate toward zero, then saturate
  function automatic logic signed [31:0] mulq_post(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p[65] ? p + 66'sd65535 : p;
    return sat32(t >>> 16);
  endfunction

endpackage

@@ design/flocking_agent_update.sv @@
// Flocking step for one agent. A batch opens with the agent's own word (tuser high) and
// continues with its neighbour words, the last one flagged by tlast; only that word yields a
// result. A self word, a neighbour of the other kind and a neighbour beyond the neighbour limit
// are taken in the idle state alone; a same-kind neighbour also passes the torus state, and when
// both torus distances fit in 31 bits, the three squares of the separation test on the shared
// multiplier. Batch end runs a sequencer over one registered multiplier, a 48-step restoring
// divider and a 32-step square root unit: each normalisation shifts the components into range,
// squares them, takes a root and two divides, and the averages, when taken, add four more
// divides. No word is taken meanwhile; a finished result waits in the output register while the
// next batch loads.
module flocking_agent_update #(
  parameter int MAX_NEIGHBOURS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, vel_x, vel_y, predator, speed_cap
  input  logic [159:0] s_tdata,
  // is_self
  input  logic         s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y, two zero bits
  output logic [127:0] m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import fau_pkg::*;

  localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);

  typedef enum logic [32:0] {
    S_IDLE    = 33'h1,
    S_NB_TOR  = 33'h1 << 1,
    S_NB_SQ0  = 33'h1 << 2,
    S_NB_SQ1  = 33'h1 << 3,
    S_NB_SQ2  = 33'h1 << 4,
    S_NB_SQ3  = 33'h1 << 5,
    S_FIN     = 33'h1 << 6,
    S_AVG_X   = 33'h1 << 7,
    S_AVG_XW  = 33'h1 << 8,
    S_AVG_Y   = 33'h1 << 9,
    S_AVG_YW  = 33'h1 << 10,
    S_SEPS    = 33'h1 << 11,
    S_N_START = 33'h1 << 12,
    S_N_SHIFT = 33'h1 << 13,
    S_N_SQ0   = 33'h1 << 14,
    S_N_SQ1   = 33'h1 << 15,
    S_N_SQ2   = 33'h1 << 16,
    S_N_ROOT  = 33'h1 << 17,
    S_N_ROOTW = 33'h1 << 18,
    S_N_DIVX  = 33'h1 << 19,
    S_N_DIVXW = 33'h1 << 20,
    S_N_DIVY  = 33'h1 << 21,
    S_N_DIVYW = 33'h1 << 22,
    S_PM0     = 33'h1 << 23,
    S_PM1     = 33'h1 << 24,
    S_PM2     = 33'h1 << 25,
    S_PMD     = 33'h1 << 26,
    S_LIM0    = 33'h1 << 27,
    S_LIM1    = 33'h1 << 28,
    S_LIM2    = 33'h1 << 29,
    S_LIM3    = 33'h1 << 30,
    S_NV      = 33'h1 << 31,
    S_WRAP    = 33'h1 << 32
  } state_t;

  typedef enum logic [7:0] {
    C_ALIGN = 8'h01,
    C_COH   = 8'h02,
    C_ESC   = 8'h04,
    C_SEP   = 8'h08,
    C_BOOST = 8'h10,
    C_SCALE = 8'h20,
    C_FLIM  = 8'h40,
    C_VLIM  = 8'h80
  } ctx_t;

  state_t state;
  ctx_t   ctx;

  logic [30:0] align_w, coh_w, sep_w, sep_dist, acc_scale, max_force, world_w, world_h;

  logic signed [31:0] own_px, own_py, own_vx, own_vy;
  logic               own_pred;
  logic [30:0]        own_cap;
  logic signed [39:0] vsx, vsy, psx, psy, rsx, rsy;
  logic [CNT_W-1:0]   cnt;
  logic               pseen;
  logic signed [31:0] edx, edy;

  logic signed [31:0] npx, npy;
  logic               last_r;
  logic [30:0]        dx_r, dy_r;
  logic [63:0]        sq;
  logic signed [41:0] wx, wy;
  logic [41:0]        mx, my;
  logic               sgx, sgy;
  logic signed [31:0] vx_r, vy_r;
  logic signed [33:0] accx, accy;

  logic [30:0]        o_px, o_py;
  logic signed [31:0] o_vx, o_vy;
  logic               out_valid;

  // input word fields
  logic               in_self, in_pred, in_last;
  logic signed [31:0] in_px, in_py, in_vx, in_vy;
  logic [30:0]        in_cap;

  assign in_self = s_tuser;
  assign in_last = s_tlast;
  assign in_px   = s_tdata[31:0];
  assign in_py   = s_tdata[63:32];
  assign in_vx   = s_tdata[95:64];
  assign in_vy   = s_tdata[127:96];
  assign in_pred = s_tdata[128];
  assign in_cap  = s_tdata[159:129];

  logic accept, take, out_free, clr_sums;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign take     = accept && !in_self && (cnt < CNT_W'(MAX_NEIGHBOURS));
  assign out_free = !out_valid || m_tready;
  assign clr_sums = (accept && in_self) || ((state == S_WRAP) && out_free);

  // shared units
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic                      div_start, sqrt_start;
  logic [DIV_W-1:0]          div_dividend, div_q;
  logic [DVS_W-1:0]          div_divisor;
  logic [ROOT_W-1:0]         sqrt_root;
  unit_stat_t                div_stat, sqrt_stat;

  fau_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  fau_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .quotient(div_q), .stat(div_stat)
  );

  fau_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(sq),
    .root(sqrt_root), .stat(sqrt_stat)
  );

  function automatic logic [39:0] mag40(input logic signed [39:0] v);
    return v[39] ? 40'(-v) : 40'(v);
  endfunction

  function automatic logic [32:0] torus(input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic [30:0] w);
    logic signed [32:0] df;
    logic [32:0]        d, wz;
    df = 33'(a) - 33'(b);
    d  = df[32] ? 33'(-df) : 33'(df);
    wz = {2'b00, w};
    if (d > (wz >> 1)) d = (d > wz) ? d - wz : wz - d;
    return d;
  endfunction

  function automatic logic [30:0] wrap(input logic signed [31:0] a,
                                       input logic signed [31:0] v,
                                       input logic [30:0] w);
    logic signed [34:0] p, wz;
    logic [30:0]        r;
    wz = signed'({4'b0000, w});
    p  = 35'(a) + 35'(v);
    if (p < 35'sd0) p = p + wz;
    if (p >= wz) p = p - wz;
    if (p < 35'sd0) r = '0;
    else if (p > 35'sd2147483647) r = 31'h7fffffff;
    else r = p[30:0];
    return r;
  endfunction

  // neighbour helpers
  logic signed [32:0] off_x, off_y, half_x, half_y;
  logic [32:0]        tdx, tdy;

  always_comb begin
    off_x  = 33'(in_px) - 33'(own_px);
    off_y  = 33'(in_py) - 33'(own_py);
    half_x = off_x + signed'({32'b0, off_x[32]});
    half_y = off_y + signed'({32'b0, off_y[32]});
    half_x = half_x >>> 1;
    half_y = half_y >>> 1;
    tdx    = torus(own_px, npx, world_w);
    tdy    = torus(own_py, npy, world_h);
  end

  // batch-end selections
  logic signed [39:0] sel_sx, sel_sy;
  logic signed [31:0] sel_ox, sel_oy, k_sel;
  logic [30:0]        lim_sel;
  logic signed [32:0] abs_vx, abs_vy;
  logic signed [41:0] qa;
  logic [41:0]        or_m;

  always_comb begin
    sel_sx  = (ctx == C_ALIGN) ? vsx : psx;
    sel_sy  = (ctx == C_ALIGN) ? vsy : psy;
    sel_ox  = (ctx == C_ALIGN) ? own_vx : own_px;
    sel_oy  = (ctx == C_ALIGN) ? own_vy : own_py;
    lim_sel = (ctx == C_VLIM) ? own_cap : max_force;
    abs_vx  = vx_r[31] ? -33'(vx_r) : 33'(vx_r);
    abs_vy  = vy_r[31] ? -33'(vy_r) : 33'(vy_r);
    qa      = signed'({2'b00, div_q[39:0]});
    or_m    = mx | my;
    unique case (ctx)
      C_ALIGN: k_sel = signed'({1'b0, align_w});
      C_COH:   k_sel = signed'({1'b0, coh_w});
      C_ESC:   k_sel = ESCAPE_FACTOR_Q16;
      C_SEP:   k_sel = signed'({1'b0, sep_w});
      C_BOOST: k_sel = PREDATOR_ACCEL_BOOST_Q16;
      C_SCALE: k_sel = signed'({1'b0, acc_scale});
      C_FLIM:  k_sel = signed'({1'b0, max_force});
      C_VLIM:  k_sel = signed'({1'b0, own_cap});
      default: k_sel = '0;
    endcase
  end

  // operand routing for the shared units
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_NB_SQ0: begin mul_a = signed'({2'b00, dx_r}); mul_b = mul_a; end
      S_NB_SQ1: begin mul_a = signed'({2'b00, dy_r}); mul_b = mul_a; end
      S_NB_SQ2: begin mul_a = signed'({2'b00, sep_dist}); mul_b = mul_a; end
      S_N_SQ0:  begin mul_a = signed'({2'b00, mx[30:0]}); mul_b = mul_a; end
      S_N_SQ1:  begin mul_a = signed'({2'b00, my[30:0]}); mul_b = mul_a; end
      S_PM0: begin
        mul_a = (ctx == C_ESC) ? -33'(vx_r) : 33'(vx_r);
        mul_b = 33'(k_sel);
      end
      S_PM1: begin
        mul_a = (ctx == C_ESC) ? -33'(vy_r) : 33'(vy_r);
        mul_b = 33'(k_sel);
      end
      S_LIM0: begin mul_a = abs_vx; mul_b = abs_vx; end
      S_LIM1: begin mul_a = abs_vy; mul_b = abs_vy; end
      S_LIM2: begin mul_a = signed'({2'b00, lim_sel}); mul_b = mul_a; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start  = (state == S_AVG_X) || (state == S_AVG_Y) ||
                 (state == S_N_DIVX) || (state == S_N_DIVY);
    sqrt_start = (state == S_N_ROOT);
    if ((state == S_AVG_X) || (state == S_AVG_Y)) begin
      div_dividend = {8'b0, (state == S_AVG_X) ? mag40(sel_sx) : mag40(sel_sy)};
      div_divisor  = DVS_W'(cnt);
    end else begin
      div_dividend = {1'b0, (state == S_N_DIVX) ? mx[30:0] : my[30:0], 16'b0};
      div_divisor  = sqrt_root;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      align_w   <= 31'd65536;
      coh_w     <= 31'd65536;
      sep_w     <= 31'd65536;
      sep_dist  <= 31'd1638400;
      acc_scale <= 31'd65536;
      max_force <= 31'd65536;
      world_w   <= 31'd52428800;
      world_h   <= 31'd39321600;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALIGN_W:   align_w   <= cfg_data;
        CFG_COH_W:     coh_w     <= cfg_data;
        CFG_SEP_W:     sep_w     <= cfg_data;
        CFG_SEP_DIST:  sep_dist  <= cfg_data;
        CFG_ACC_SCALE: acc_scale <= cfg_data;
        CFG_MAX_FORCE: max_force <= cfg_data;
        CFG_WORLD_W:   world_w   <= cfg_data;
        CFG_WORLD_H:   world_h   <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ctx       <= C_ALIGN;
      out_valid <= 1'b0;
      own_px    <= '0;
      own_py    <= '0;
      own_vx    <= '0;
      own_vy    <= '0;
      own_pred  <= 1'b0;
      own_cap   <= '0;
      vsx       <= '0;
      vsy       <= '0;
      psx       <= '0;
      psy       <= '0;
      rsx       <= '0;
      rsy       <= '0;
      cnt       <= '0;
      pseen     <= 1'b0;
      edx       <= '0;
      edy       <= '0;
    end else begin
      if (out_valid && m_tready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            npx    <= in_px;
            npy    <= in_py;
            last_r <= in_last;
            if (in_self) begin
              own_px   <= in_px;
              own_py   <= in_py;
              own_vx   <= in_vx;
              own_vy   <= in_vy;
              own_pred <= in_pred;
              own_cap  <= in_cap;
              state    <= in_last ? S_FIN : S_IDLE;
            end else if (take) begin
              cnt <= cnt + 1'b1;
              vsx <= sat40(42'(vsx) + 42'(in_vx));
              vsy <= sat40(42'(vsy) + 42'(in_vy));
              psx <= sat40(42'(psx) + 42'(in_px));
              psy <= sat40(42'(psy) + 42'(in_py));
              if (in_pred && !pseen) begin
                pseen <= 1'b1;
                edx   <= half_x[31:0];
                edy   <= half_y[31:0];
              end
              if (in_pred == own_pred) state <= S_NB_TOR;
              else state <= in_last ? S_FIN : S_IDLE;
            end else begin
              state <= in_last ? S_FIN : S_IDLE;
            end
          end
        end

        S_NB_TOR: begin
          if (tdx[32:31] == 2'b00 && tdy[32:31] == 2'b00) begin
            dx_r  <= tdx[30:0];
            dy_r  <= tdy[30:0];
            state <= S_NB_SQ0;
          end else begin
            state <= last_r ? S_FIN : S_IDLE;
          end
        end
        S_NB_SQ0: state <= S_NB_SQ1;
        S_NB_SQ1: begin
          sq    <= mul_p[63:0];
          state <= S_NB_SQ2;
        end
        S_NB_SQ2: begin
          sq    <= sq + mul_p[63:0];
          state <= S_NB_SQ3;
        end
        S_NB_SQ3: begin
          if (sq < mul_p[63:0]) begin
            rsx <= sat40(42'(rsx) - (42'(npx) - 42'(own_px)));
            rsy <= sat40(42'(rsy) - (42'(npy) - 42'(own_py)));
          end
          state <= last_r ? S_FIN : S_IDLE;
        end

        S_FIN: begin
          accx <= '0;
          accy <= '0;
          if (!pseen && cnt != '0) begin
            ctx   <= C_ALIGN;
            state <= S_AVG_X;
          end else begin
            state <= S_SEPS;
          end
        end

        // averages truncate toward zero, minus own value
        S_AVG_X: state <= S_AVG_XW;
        S_AVG_XW: begin
          if (div_stat.done) begin
            wx    <= (sel_sx[39] ? -qa : qa) - 42'(sel_ox);
            state <= S_AVG_Y;
          end
        end
        S_AVG_Y: state <= S_AVG_YW;
        S_AVG_YW: begin
          if (div_stat.done) begin
            wy    <= (sel_sy[39] ? -qa : qa) - 42'(sel_oy);
            state <= S_N_START;
          end
        end

        S_SEPS: begin
          if (!own_pred && pseen) begin
            wx  <= 42'(edx);
            wy  <= 42'(edy);
            ctx <= C_ESC;
          end else begin
            wx  <= 42'(rsx);
            wy  <= 42'(rsy);
            ctx <= C_SEP;
          end
          state <= S_N_START;
        end

        // normalise: bring the larger component into [2^30, 2^31); a zero vector gives zero
        S_N_START: begin
          mx    <= wx[41] ? 42'(-wx) : 42'(wx);
          my    <= wy[41] ? 42'(-wy) : 42'(wy);
          sgx   <= wx[41];
          sgy   <= wy[41];
          state <= S_N_SHIFT;
        end
        S_N_SHIFT: begin
          if (or_m == '0) begin
            vx_r  <= '0;
            vy_r  <= '0;
            state <= S_PM0;
          end else if (or_m[41:31] != '0) begin
            mx <= mx >> 1;
            my <= my >> 1;
          end else if (!or_m[30]) begin
            mx <= mx << 1;
            my <= my << 1;
          end else begin
            state <= S_N_SQ0;
          end
        end
        S_N_SQ0: state <= S_N_SQ1;
        S_N_SQ1: begin
          sq    <= mul_p[63:0];
          state <= S_N_SQ2;
        end
        S_N_SQ2: begin
          sq    <= sq + mul_p[63:0];
          state <= S_N_ROOT;
        end
        S_N_ROOT: state <= S_N_ROOTW;
        S_N_ROOTW: if (sqrt_stat.done) state <= S_N_DIVX;
        S_N_DIVX: state <= S_N_DIVXW;
        S_N_DIVXW: begin
          if (div_stat.done) begin
            vx_r  <= sgx ? -signed'(div_q[31:0]) : signed'(div_q[31:0]);
            state <= S_N_DIVY;
          end
        end
        S_N_DIVY: state <= S_N_DIVYW;
        S_N_DIVYW: begin
          if (div_stat.done) begin
            vy_r  <= sgy ? -signed'(div_q[31:0]) : signed'(div_q[31:0]);
            state <= S_PM0;
          end
        end

        // vector times scalar on the shared multiplier
        S_PM0: state <= S_PM1;
        S_PM1: begin
          vx_r  <= mulq_post(mul_p);
          state <= S_PM2;
        end
        S_PM2: begin
          vy_r  <= mulq_post(mul_p);
          state <= S_PMD;
        end
        S_PMD: begin
          unique case (ctx)
            C_ALIGN: begin
              accx  <= accx + 34'(vx_r);
              accy  <= accy + 34'(vy_r);
              ctx   <= C_COH;
              state <= S_AVG_X;
            end
            C_COH: begin
              accx  <= accx + 34'(vx_r);
              accy  <= accy + 34'(vy_r);
              state <= S_SEPS;
            end
            C_ESC: begin
              ctx   <= C_SEP;
              state <= S_PM0;
            end
            C_SEP: begin
              vx_r  <= sat32(66'(accx) + 66'(vx_r));
              vy_r  <= sat32(66'(accy) + 66'(vy_r));
              ctx   <= own_pred ? C_BOOST : C_SCALE;
              state <= S_PM0;
            end
            C_BOOST: begin
              ctx   <= C_SCALE;
              state <= S_PM0;
            end
            C_SCALE: begin
              ctx   <= C_FLIM;
              state <= S_LIM0;
            end
            C_FLIM: state <= S_NV;
            C_VLIM: state <= S_WRAP;
            default: state <= S_IDLE;
          endcase
        end

        // magnitude limit: compare squared magnitude with squared limit
        S_LIM0: state <= S_LIM1;
        S_LIM1: begin
          sq    <= mul_p[63:0];
          state <= S_LIM2;
        end
        S_LIM2: begin
          sq    <= sq + mul_p[63:0];
          state <= S_LIM3;
        end
        S_LIM3: begin
          if (sq > mul_p[63:0]) begin
            wx    <= 42'(vx_r);
            wy    <= 42'(vy_r);
            state <= S_N_START;
          end else begin
            state <= (ctx == C_VLIM) ? S_WRAP : S_NV;
          end
        end

        S_NV: begin
          vx_r  <= sat32(66'(own_vx) + 66'(vx_r));
          vy_r  <= sat32(66'(own_vy) + 66'(vy_r));
          ctx   <= C_VLIM;
          state <= S_LIM0;
        end

        S_WRAP: begin
          if (out_free) begin
            o_px      <= wrap(own_px, vx_r, world_w);
            o_py      <= wrap(own_py, vy_r, world_h);
            o_vx      <= vx_r;
            o_vy      <= vy_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      if (clr_sums) begin
        vsx   <= '0;
        vsy   <= '0;
        psx   <= '0;
        psy   <= '0;
        rsx   <= '0;
        rsy   <= '0;
        cnt   <= '0;
        pseen <= 1'b0;
        edx   <= '0;
        edy   <= '0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, o_vy, o_vx, o_py, o_px};

  a_out_from_wrap: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_WRAP))
    else $error("output loaded outside the wrap step");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_N_SQ0) |-> (mx[41:31] == '0 && my[41:31] == '0 && (mx[30] || my[30])))
    else $error("normalised components out of range");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_N_DIVX) |-> (sqrt_root[31] || sqrt_root[30]))
    else $error("root below 2^30 before the divide");

endmodule

@@ design/fau_mul.sv @@
module fau_mul (
  input  logic                                 clk,
  input  logic signed [fau_pkg::MUL_W-1:0]     a,
  input  logic signed [fau_pkg::MUL_W-1:0]     b,
  output logic signed [2*fau_pkg::MUL_W-1:0]   p
);
  import fau_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ design/fau_div.sv @@
module fau_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fau_pkg::DIV_W-1:0]     dividend,
  input  logic [fau_pkg::DVS_W-1:0]     divisor,
  output logic [fau_pkg::DIV_W-1:0]     quotient,
  output fau_pkg::unit_stat_t           stat
);
  import fau_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  q;
  logic [DVS_W:0]    rem;
  logic [DVS_W-1:0]  d;
  logic [STEP_W-1:0] step;
  logic [DVS_W:0]    rem_sh;
  logic              ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem[DVS_W-1:0], q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      step <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        q         <= dividend;
        rem       <= '0;
        d         <= divisor;
        step      <= STEP_W'(DIV_W);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem  <= ge ? rem_sh - {1'b0, d} : rem_sh;
        q    <= {q[DIV_W-2:0], ge};
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

@@ design/fau_sqrt.sv @@
module fau_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fau_pkg::SQ_W-1:0]      radicand,
  output logic [fau_pkg::ROOT_W-1:0]    root,
  output fau_pkg::unit_stat_t           stat
);
  import fau_pkg::*;

  localparam int STEPS  = SQ_W / 2;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic [SQ_W-1:0]   n;
  logic [SQ_W-1:0]   r;
  logic [SQ_W-1:0]   bitv;
  logic [STEP_W-1:0] step;
  logic [SQ_W:0]     t;
  logic              ge;

  // digit-by-digit floor square root, two radicand bits a cycle
  always_comb begin
    t  = {1'b0, r} + {1'b0, bitv};
    ge = {1'b0, n} >= t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      step <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        n         <= radicand;
        r         <= '0;
        bitv      <= {2'b01, {(SQ_W-2){1'b0}}};
        step      <= STEP_W'(STEPS);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (ge) begin
          n <= n - t[SQ_W-1:0];
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  assign root = r[ROOT_W-1:0];

endmodule
